@@ src/fadc_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types, microcode codes and breakpoint tables of the fader converter.
package fadc_pkg;

  localparam int FADER_COUNT = 8;
  localparam int INDEX_W     = 8;
  localparam int SAMPLE_W    = 12;
  localparam int OUT_W       = 7;
  localparam int MASK_W      = 8;
  localparam int ADDR_W      = (FADER_COUNT > 1) ? $clog2(FADER_COUNT) : 1;
  localparam int SEG_W       = 4;
  localparam int SEG_LAST    = 13;
  localparam int DY_W        = 4;
  localparam int QUOT_W      = 4;
  localparam int CNT_W       = 2;
  localparam int NUM_W       = SAMPLE_W + DY_W;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [INDEX_W-1:0] FADER_LIMIT = INDEX_W'(FADER_COUNT);
  localparam logic [INDEX_W-1:0] MASK_LIMIT  = INDEX_W'(MASK_W);

  localparam logic REQ_STORE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  localparam logic REG_LOG_MODE_MASK = 1'b0;

  typedef logic [2:0] upc_t;
  typedef logic [2:0] op_t;
  typedef logic [2:0] br_t;

  localparam upc_t UPC_FETCH  = 3'd0;
  localparam upc_t UPC_ACCESS = 3'd1;
  localparam upc_t UPC_SEARCH = 3'd2;
  localparam upc_t UPC_SETUP  = 3'd3;
  localparam upc_t UPC_DIV    = 3'd4;
  localparam upc_t UPC_EMIT   = 3'd5;

  localparam op_t OP_NOP    = 3'd0;
  localparam op_t OP_LATCH  = 3'd1;
  localparam op_t OP_ACCESS = 3'd2;
  localparam op_t OP_SEARCH = 3'd3;
  localparam op_t OP_SETUP  = 3'd4;
  localparam op_t OP_DIV    = 3'd5;
  localparam op_t OP_EMIT   = 3'd6;

  localparam br_t BR_NEXT   = 3'd0;
  localparam br_t BR_JUMP   = 3'd1;
  localparam br_t BR_IN     = 3'd2;
  localparam br_t BR_STORE  = 3'd3;
  localparam br_t BR_DIRECT = 3'd4;
  localparam br_t BR_LOOP   = 3'd5;
  localparam br_t BR_OUT    = 3'd6;

  typedef struct packed {
    op_t  op;
    br_t  br;
    upc_t target;
  } ctl_word_t;

  typedef struct packed {
    logic is_store;
    logic direct;
    logic cnt_zero;
    logic out_busy;
    logic den_nz;
  } dp_stat_t;

  function automatic logic [SAMPLE_W-1:0] brk_in_at(input logic [SEG_W-1:0] k);
    logic [SAMPLE_W-1:0] v;
    unique case (k)
      4'd0:    v = 12'd0;
      4'd1:    v = 12'd44;
      4'd2:    v = 12'd120;
      4'd3:    v = 12'd222;
      4'd4:    v = 12'd345;
      4'd5:    v = 12'd470;
      4'd6:    v = 12'd590;
      4'd7:    v = 12'd895;
      4'd8:    v = 12'd1715;
      4'd9:    v = 12'd2465;
      4'd10:   v = 12'd3220;
      4'd11:   v = 12'd4050;
      4'd12:   v = 12'd4094;
      4'd13:   v = 12'd4095;
      default: v = 12'd0;
    endcase
    return v;
  endfunction

  function automatic logic [OUT_W-1:0] brk_out_at(input logic [SEG_W-1:0] k);
    logic [OUT_W-1:0] v;
    unique case (k)
      4'd0:    v = 7'd0;
      4'd1:    v = 7'd10;
      4'd2:    v = 7'd21;
      4'd3:    v = 7'd31;
      4'd4:    v = 7'd42;
      4'd5:    v = 7'd52;
      4'd6:    v = 7'd63;
      4'd7:    v = 7'd74;
      4'd8:    v = 7'd84;
      4'd9:    v = 7'd95;
      4'd10:   v = 7'd105;
      4'd11:   v = 7'd116;
      4'd12:   v = 7'd127;
      4'd13:   v = 7'd127;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

  // breakpoints rise strictly, so the segment is the count of those below the sample
  function automatic logic [SEG_W-1:0] seg_of(input logic [SAMPLE_W-1:0] s);
    logic [SEG_W-1:0] k;
    k = '0;
    for (int j = 0; j < SEG_LAST; j++) begin
      if (s > brk_in_at(SEG_W'(j))) k = k + 1'b1;
    end
    return k;
  endfunction

endpackage

@@ src/fader_adc_to_midi_converter_unit.sv @@
`timescale 1ns / 1ps
// Top level of the fader converter: configuration register, sequencer and datapath.
//
// Input channel (in_valid/in_stall): a store request writes a 12-bit sample for one
// fader; a read request returns that fader's 0..127 MIDI value on the output channel
// (out_valid/out_stall). Indexes beyond the fader count: stores are dropped, reads
// return 0. A transfer takes place when valid is high and stall is low.
// The register log_mode_mask (APB, byte address 0) picks plain scaling per fader;
// otherwise the value is interpolated over the 14-point breakpoint table.
// A microcoded sequencer works on one request at a time: a store runs the fetch and
// access steps; a read adds search, setup and emit when the result is direct (scaled,
// exact breakpoint, out of range), and the bit-serial divider when it interpolates.
// The result sits in an output register, so the next request is taken while it waits.
// A stalled result holds the sequencer at its emit step until the transfer completes.
// Reset clears every stored sample, the mask and the pending result.
module fader_adc_to_midi_converter_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_req_type,
  input  logic [fadc_pkg::INDEX_W-1:0]    in_fader_index,
  input  logic [fadc_pkg::SAMPLE_W-1:0]   in_raw_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [fadc_pkg::OUT_W-1:0]      out_fader_value,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fadc_pkg::PADDR_W-1:0]    paddr,
  input  logic [fadc_pkg::PDATA_W-1:0]    pwdata,
  output logic [fadc_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);

  logic [fadc_pkg::MASK_W-1:0] log_mode_mask_r;
  fadc_pkg::ctl_word_t         cw;
  fadc_pkg::dp_stat_t          stat;
  fadc_pkg::upc_t              upc;
  logic                        reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == fadc_pkg::REG_LOG_MODE_MASK);
  assign prdata  = reg_hit ? fadc_pkg::PDATA_W'(log_mode_mask_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_mode_mask_r <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      log_mode_mask_r <= pwdata[fadc_pkg::MASK_W-1:0];
    end
  end

  fadc_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .cw       (cw),
    .upc      (upc),
    .in_stall (in_stall)
  );

  fadc_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cw              (cw),
    .in_valid        (in_valid),
    .in_req_type     (in_req_type),
    .in_fader_index  (in_fader_index),
    .in_raw_sample   (in_raw_sample),
    .log_mode_mask   (log_mode_mask_r),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_fader_value (out_fader_value),
    .stat            (stat)
  );

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(upc == fadc_pkg::UPC_EMIT))
    else $error("result raised outside the emit step");

  a_div_den_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (upc == fadc_pkg::UPC_DIV) |-> stat.den_nz)
    else $error("divider running with a zero segment width");

  a_store_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_req_type == fadc_pkg::REQ_STORE))
      |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("store request produced a result");

endmodule

@@ src/fadc_ucode_rom.sv @@
`timescale 1ns / 1ps
// Microcode program store of the fader converter.
module fadc_ucode_rom (
  input  fadc_pkg::upc_t      upc,
  output fadc_pkg::ctl_word_t cw
);

  always_comb begin
    unique case (upc)
      fadc_pkg::UPC_FETCH:
        cw = '{fadc_pkg::OP_LATCH,  fadc_pkg::BR_IN,     fadc_pkg::UPC_FETCH};
      fadc_pkg::UPC_ACCESS:
        cw = '{fadc_pkg::OP_ACCESS, fadc_pkg::BR_STORE,  fadc_pkg::UPC_FETCH};
      fadc_pkg::UPC_SEARCH:
        cw = '{fadc_pkg::OP_SEARCH, fadc_pkg::BR_NEXT,   fadc_pkg::UPC_SETUP};
      fadc_pkg::UPC_SETUP:
        cw = '{fadc_pkg::OP_SETUP,  fadc_pkg::BR_DIRECT, fadc_pkg::UPC_EMIT};
      fadc_pkg::UPC_DIV:
        cw = '{fadc_pkg::OP_DIV,    fadc_pkg::BR_LOOP,   fadc_pkg::UPC_DIV};
      fadc_pkg::UPC_EMIT:
        cw = '{fadc_pkg::OP_EMIT,   fadc_pkg::BR_OUT,    fadc_pkg::UPC_FETCH};
      default:
        cw = '{fadc_pkg::OP_NOP,    fadc_pkg::BR_JUMP,   fadc_pkg::UPC_FETCH};
    endcase
  end

endmodule

@@ src/fadc_sequencer.sv @@
`timescale 1ns / 1ps
// Step counter and branch logic driving the fader converter datapath.
module fadc_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  fadc_pkg::dp_stat_t  stat,
  output fadc_pkg::ctl_word_t cw,
  output fadc_pkg::upc_t      upc,
  output logic                in_stall
);

  fadc_pkg::upc_t upc_r;
  fadc_pkg::upc_t upc_nxt;
  fadc_pkg::upc_t upc_inc;

  fadc_ucode_rom u_rom (
    .upc (upc_r),
    .cw  (cw)
  );

  assign upc_inc  = upc_r + 1'b1;
  assign upc      = upc_r;
  assign in_stall = (upc_r != fadc_pkg::UPC_FETCH);

  always_comb begin
    unique case (cw.br)
      fadc_pkg::BR_NEXT:   upc_nxt = upc_inc;
      fadc_pkg::BR_JUMP:   upc_nxt = cw.target;
      fadc_pkg::BR_IN:     upc_nxt = in_valid ? upc_inc : upc_r;
      fadc_pkg::BR_STORE:  upc_nxt = stat.is_store ? cw.target : upc_inc;
      fadc_pkg::BR_DIRECT: upc_nxt = stat.direct ? cw.target : upc_inc;
      fadc_pkg::BR_LOOP:   upc_nxt = stat.cnt_zero ? upc_inc : cw.target;
      fadc_pkg::BR_OUT:    upc_nxt = stat.out_busy ? upc_r : cw.target;
      default:             upc_nxt = fadc_pkg::UPC_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= fadc_pkg::UPC_FETCH;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

@@ src/fadc_datapath.sv @@
`timescale 1ns / 1ps
// Sample store, segment search, multiply, bit-serial divider and result register.
module fadc_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fadc_pkg::ctl_word_t                 cw,
  input  logic                                in_valid,
  input  logic                                in_req_type,
  input  logic [fadc_pkg::INDEX_W-1:0]        in_fader_index,
  input  logic [fadc_pkg::SAMPLE_W-1:0]       in_raw_sample,
  input  logic [fadc_pkg::MASK_W-1:0]         log_mode_mask,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [fadc_pkg::OUT_W-1:0]          out_fader_value,
  output fadc_pkg::dp_stat_t                  stat
);

  logic                          req_r;
  logic [fadc_pkg::INDEX_W-1:0]  idx_r;
  logic [fadc_pkg::SAMPLE_W-1:0] raw_r;
  logic [fadc_pkg::SAMPLE_W-1:0] s_r;
  logic [fadc_pkg::SEG_W-1:0]    k_r;
  logic [fadc_pkg::NUM_W-1:0]    num_r;
  logic [fadc_pkg::SAMPLE_W-1:0] den_r;
  logic [fadc_pkg::CNT_W-1:0]    cnt_r;
  logic [fadc_pkg::QUOT_W-1:0]   q_r;
  logic [fadc_pkg::OUT_W-1:0]    res_r;
  logic                          direct_r;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic [fadc_pkg::OUT_W-1:0]    out_val_r;
  logic [fadc_pkg::SAMPLE_W-1:0] store_r [fadc_pkg::FADER_COUNT];

  logic                          in_range;
  logic                          is_log;
  logic [fadc_pkg::ADDR_W-1:0]   addr;
  logic [fadc_pkg::SEG_W-1:0]    km1;
  logic [fadc_pkg::SAMPLE_W-1:0] x0;
  logic [fadc_pkg::SAMPLE_W-1:0] x1;
  logic [fadc_pkg::OUT_W-1:0]    y0;
  logic [fadc_pkg::OUT_W-1:0]    y1;
  logic [fadc_pkg::DY_W-1:0]     dy;
  logic                          exact;
  logic                          direct;
  logic [fadc_pkg::OUT_W-1:0]    direct_val;
  logic [fadc_pkg::NUM_W-1:0]    trial;
  logic                          out_busy;
  logic                          emit_go;

  assign in_range = (idx_r < fadc_pkg::FADER_LIMIT);
  assign addr     = idx_r[fadc_pkg::ADDR_W-1:0];
  assign is_log   = (idx_r < fadc_pkg::MASK_LIMIT) && log_mode_mask[idx_r[2:0]];

  assign km1   = k_r - 1'b1;
  assign x0    = fadc_pkg::brk_in_at(km1);
  assign x1    = fadc_pkg::brk_in_at(k_r);
  assign y0    = fadc_pkg::brk_out_at(km1);
  assign y1    = fadc_pkg::brk_out_at(k_r);
  assign dy    = fadc_pkg::DY_W'(y1 - y0);
  assign exact = (s_r == x1);

  assign direct = !in_range || is_log || (k_r == '0) || exact;

  always_comb begin
    if (!in_range) begin
      direct_val = '0;
    end else if (is_log) begin
      direct_val = s_r[fadc_pkg::SAMPLE_W-1 -: fadc_pkg::OUT_W];
    end else if ((k_r == '0) || exact) begin
      direct_val = y1;
    end else begin
      direct_val = y0;
    end
  end

  assign trial    = fadc_pkg::NUM_W'(den_r) << cnt_r;
  assign out_busy = out_valid_r && out_stall;
  assign emit_go  = (cw.op == fadc_pkg::OP_EMIT) && !out_busy;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_go) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < fadc_pkg::FADER_COUNT; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if ((cw.op == fadc_pkg::OP_ACCESS) && (req_r == fadc_pkg::REQ_STORE) && in_range) begin
        store_r[addr] <= raw_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cw.op)
      fadc_pkg::OP_LATCH: begin
        if (in_valid) begin
          req_r <= in_req_type;
          idx_r <= in_fader_index;
          raw_r <= in_raw_sample;
        end
      end
      fadc_pkg::OP_ACCESS: begin
        s_r <= in_range ? store_r[addr] : '0;
      end
      fadc_pkg::OP_SEARCH: begin
        k_r <= fadc_pkg::seg_of(s_r);
      end
      fadc_pkg::OP_SETUP: begin
        num_r    <= fadc_pkg::NUM_W'(s_r - x0) * fadc_pkg::NUM_W'(dy);
        den_r    <= x1 - x0;
        cnt_r    <= fadc_pkg::CNT_W'(fadc_pkg::QUOT_W - 1);
        q_r      <= '0;
        direct_r <= direct;
        res_r    <= direct_val;
      end
      fadc_pkg::OP_DIV: begin
        if (num_r >= trial) begin
          num_r     <= num_r - trial;
          q_r[cnt_r] <= 1'b1;
        end
        cnt_r <= cnt_r - 1'b1;
      end
      fadc_pkg::OP_EMIT: begin
        if (!out_busy) begin
          out_val_r <= direct_r ? res_r : res_r + fadc_pkg::OUT_W'(q_r);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_fader_value = out_val_r;

  assign stat.is_store = (req_r == fadc_pkg::REQ_STORE);
  assign stat.direct   = direct;
  assign stat.cnt_zero = (cnt_r == '0);
  assign stat.out_busy = out_busy;
  assign stat.den_nz   = (den_r != '0);

endmodule
